>>> sv/ffea_pkg.sv
// Package for the first-fit extent allocator.
// Holds command and status codes shared by the design; no dependencies.
`timescale 1ns / 1ps
package ffea_pkg;
  localparam int CmdW = 2;
  localparam int StatusW = 2;
  localparam int CountW = 27;
  localparam int LenW = 32;
  localparam int AddrBits = 32;
  localparam int MinRemainder = 16;

  localparam logic [CmdW-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CmdW-1:0] CMD_FREE = 2'd1;
  localparam logic [CmdW-1:0] CMD_INIT = 2'd2;
  localparam logic [CmdW-1:0] CMD_NOP = 2'd3;

  localparam logic [StatusW-1:0] ST_OK = 2'd0;
  localparam logic [StatusW-1:0] ST_NOFIT = 2'd1;
  localparam logic [StatusW-1:0] ST_BADFREE = 2'd2;
  localparam logic [StatusW-1:0] ST_FULL = 2'd3;

  localparam logic CFG_HEAP_START = 1'b0;
  localparam logic CFG_HEAP_BYTES = 1'b1;
endpackage

>>> sv/first_fit_extent_allocator.sv
// First-fit extent allocator: a sorted table of free extents in two memories.
// Depends on ffea_pkg for command and status codes.
// A valid ALLOC or FREE command takes a search, an optional shift and a summary
// pass over the table; every other command takes only the summary pass. One
// command at a time, busy is high meanwhile. The result shows for one cycle
// on done_o; the receiver cannot stall. Reset empties the table and clears the
// heap registers.
`timescale 1ns / 1ps
module first_fit_extent_allocator
  import ffea_pkg::*;
#(
  parameter int TABLE_ENTRIES = 32,
  parameter int BLOCK_BYTES = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [CmdW-1:0]      command_i,
  input  logic [CountW-1:0]    block_count_i,
  input  logic [31:0]          chunk_address_i,
  input  logic [31:0]          chunk_bytes_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  output logic                 done_o,
  output logic [StatusW-1:0]   status_o,
  output logic [31:0]          granted_address_o,
  output logic [31:0]          total_free_o,
  output logic [31:0]          largest_free_o
);
  localparam int IdxW = (TABLE_ENTRIES > 2) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CntW = $clog2(TABLE_ENTRIES + 1);
  localparam int AW = AddrBits;
  localparam int NeedW = CountW + $clog2(BLOCK_BYTES) + 1;
  localparam int CmpW = (NeedW > LenW + 1) ? NeedW : LenW + 1;
  localparam logic [CntW-1:0] FullCnt = CntW'(TABLE_ENTRIES);

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH, S_SRCH_W, S_DECIDE, S_SHL, S_SHL_W, S_SHR, S_SHR_W,
    S_SUM, S_SUM_W, S_DONE
  } state_e;

  state_e state_q;
  logic [31:0] heap_start_q, heap_bytes_q;
  logic [CntW-1:0] cnt_q, pos_q, k_q;
  logic [CmdW-1:0] cmd_q;
  logic [NeedW-1:0] need_q;
  logic [AW-1:0] addr_q;
  logic [AW:0] end_q;
  logic [LenW-1:0] size_q;
  logic [AW-1:0] prev_s_q;
  logic [LenW-1:0] prev_l_q;
  logic has_prev_q, found_q;
  logic [StatusW-1:0] st_q;
  logic [AW-1:0] grant_q;
  logic [32:0] total_q;
  logic [LenW-1:0] largest_q;

  logic [AW-1:0] mem_s [TABLE_ENTRIES];
  logic [LenW-1:0] mem_l [TABLE_ENTRIES];
  logic [AW-1:0] rd_s_q;
  logic [LenW-1:0] rd_l_q;
  logic we;
  logic [IdxW-1:0] wa, ra;
  logic [AW-1:0] wd_s;
  logic [LenW-1:0] wd_l;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_s[wa] <= wd_s;
      mem_l[wa] <= wd_l;
    end
    rd_s_q <= mem_s[ra];
    rd_l_q <= mem_l[ra];
  end

  assign busy = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);

  logic [AW:0] prev_end;
  logic [AW:0] init_end;
  logic [AW:0] init_len;
  logic [33:0] merged;
  logic join_prev, join_next, has_next, free_bad;
  assign prev_end = {1'b0, prev_s_q} + (AW + 1)'(prev_l_q);
  assign has_next = found_q;
  assign join_prev = has_prev_q && (prev_end == {1'b0, addr_q});
  assign join_next = has_next && (end_q == {1'b0, rd_s_q});
  assign merged = 34'(size_q) + (join_prev ? 34'(prev_l_q) : 34'd0)
                  + (join_next ? 34'(rd_l_q) : 34'd0);
  assign free_bad = (has_next && end_q > {1'b0, rd_s_q})
                    || (has_prev_q && prev_end > {1'b0, addr_q})
                    || (merged[33:32] != '0);
  assign init_end = {1'b0, heap_start_q[AW-1:0]} + (AW + 1)'(heap_bytes_q);
  assign init_len = {1'b1, {AW{1'b0}}} - {1'b0, heap_start_q[AW-1:0]};

  always_comb begin
    we = 1'b0;
    wa = '0;
    wd_s = '0;
    wd_l = '0;
    ra = k_q[IdxW-1:0];
    unique case (state_q)
      S_IDLE: begin
        ra = '0;
        if (start && command_i == CMD_INIT && heap_bytes_q != '0) begin
          we = 1'b1;
          wd_s = heap_start_q[AW-1:0];
          wd_l = (init_end > (AW + 1)'(1) << AW) ? LenW'(init_len) : heap_bytes_q;
        end
      end
      S_DECIDE: begin
        wa = pos_q[IdxW-1:0];
        if (cmd_q == CMD_ALLOC && found_q
            && (CmpW'(rd_l_q) - CmpW'(need_q)) >= CmpW'(MinRemainder)) begin
          we = 1'b1;
          wd_s = rd_s_q + AW'(need_q);
          wd_l = LenW'(CmpW'(rd_l_q) - CmpW'(need_q));
        end else if (cmd_q == CMD_FREE && st_q == ST_OK && !free_bad) begin
          if (join_prev) begin
            we = 1'b1;
            wa = IdxW'(pos_q - 1'b1);
            wd_s = prev_s_q;
            wd_l = merged[31:0];
          end else if (join_next) begin
            we = 1'b1;
            wd_s = addr_q;
            wd_l = merged[31:0];
          end else if (cnt_q < FullCnt && pos_q == cnt_q) begin
            we = 1'b1;
            wd_s = addr_q;
            wd_l = size_q;
          end
        end
      end
      S_SHL: ra = IdxW'(k_q + 1'b1);
      S_SHL_W: begin
        we = 1'b1;
        wa = k_q[IdxW-1:0];
        wd_s = rd_s_q;
        wd_l = rd_l_q;
      end
      S_SHR: ra = IdxW'(k_q - 1'b1);
      S_SHR_W: begin
        we = 1'b1;
        wa = k_q[IdxW-1:0];
        if (k_q == pos_q) begin
          wd_s = addr_q;
          wd_l = size_q;
        end else begin
          wd_s = rd_s_q;
          wd_l = rd_l_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      heap_start_q <= '0;
      heap_bytes_q <= '0;
      cnt_q <= '0;
      done_o <= 1'b0;
      status_o <= ST_OK;
      granted_address_o <= '0;
      total_free_o <= '0;
      largest_free_o <= '0;
      pos_q <= '0;
      k_q <= '0;
      cmd_q <= CMD_ALLOC;
      st_q <= ST_OK;
      found_q <= 1'b0;
      has_prev_q <= 1'b0;
    end else begin
      done_o <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (cfg_valid_i) begin
            if (cfg_index_i == CFG_HEAP_START) heap_start_q <= cfg_data_i;
            else heap_bytes_q <= cfg_data_i;
          end
          if (start) begin
            cmd_q <= command_i;
            need_q <= NeedW'(block_count_i) * NeedW'(BLOCK_BYTES);
            addr_q <= AW'(chunk_address_i);
            end_q <= (AW + 1)'(chunk_address_i[AW-1:0]) + (AW + 1)'(chunk_bytes_i);
            size_q <= chunk_bytes_i;
            st_q <= ST_OK;
            grant_q <= '0;
            found_q <= 1'b0;
            has_prev_q <= 1'b0;
            pos_q <= '0;
            k_q <= '0;
            unique case (command_i)
              CMD_ALLOC: begin
                if (block_count_i == '0) st_q <= ST_NOFIT;
                state_q <= (block_count_i == '0) ? S_SUM : S_SRCH;
              end
              CMD_FREE: begin
                if (chunk_bytes_i == '0
                    || ((AW + 1)'(chunk_address_i[AW-1:0]) + (AW + 1)'(chunk_bytes_i) - 1'b1)
                       > {1'b0, {AW{1'b1}}}) begin
                  st_q <= ST_BADFREE;
                  state_q <= S_SUM;
                end else state_q <= S_SRCH;
              end
              CMD_INIT: begin
                cnt_q <= (heap_bytes_q != '0) ? CntW'(1) : '0;
                state_q <= S_SUM;
              end
              default: state_q <= S_SUM;
            endcase
          end
        end
        S_SRCH: begin
          if (k_q >= cnt_q) begin
            pos_q <= k_q;
            state_q <= S_DECIDE;
          end else state_q <= S_SRCH_W;
        end
        S_SRCH_W: begin
          if (cmd_q == CMD_ALLOC ? (CmpW'(rd_l_q) >= CmpW'(need_q)) : (rd_s_q >= addr_q)) begin
            found_q <= 1'b1;
            pos_q <= k_q;
            state_q <= S_DECIDE;
          end else begin
            prev_s_q <= rd_s_q;
            prev_l_q <= rd_l_q;
            has_prev_q <= 1'b1;
            k_q <= k_q + 1'b1;
            state_q <= S_SRCH;
          end
        end
        S_DECIDE: begin
          state_q <= S_SUM;
          k_q <= pos_q;
          if (cmd_q == CMD_ALLOC) begin
            if (!found_q) st_q <= ST_NOFIT;
            else begin
              grant_q <= rd_s_q;
              if ((CmpW'(rd_l_q) - CmpW'(need_q)) < CmpW'(MinRemainder)) state_q <= S_SHL;
            end
          end else begin
            if (free_bad) st_q <= ST_BADFREE;
            else if (join_prev) begin
              if (join_next) state_q <= S_SHL;
            end else if (join_next) begin
            end else if (cnt_q >= FullCnt) st_q <= ST_FULL;
            else if (pos_q == cnt_q) cnt_q <= cnt_q + 1'b1;
            else begin
              k_q <= cnt_q;
              state_q <= S_SHR;
            end
          end
        end
        S_SHL: begin
          if (k_q + 1'b1 >= cnt_q) begin
            cnt_q <= cnt_q - 1'b1;
            k_q <= '0;
            state_q <= S_SUM;
          end else state_q <= S_SHL_W;
        end
        S_SHL_W: begin
          k_q <= k_q + 1'b1;
          state_q <= S_SHL;
        end
        S_SHR: state_q <= S_SHR_W;
        S_SHR_W: begin
          if (k_q == pos_q) begin
            cnt_q <= cnt_q + 1'b1;
            state_q <= S_SUM;
          end else begin
            k_q <= k_q - 1'b1;
            state_q <= S_SHR;
          end
        end
        S_SUM: begin
          state_q <= S_SUM_W;
          k_q <= '0;
          total_q <= '0;
          largest_q <= '0;
        end
        S_SUM_W: begin
          if (k_q >= cnt_q + 1'b1 || cnt_q == '0) state_q <= S_DONE;
          else begin
            if (k_q != '0) begin
              total_q <= (total_q + 33'(rd_l_q) > 33'h0_FFFF_FFFF) ? 33'h0_FFFF_FFFF
                         : total_q + 33'(rd_l_q);
              if (rd_l_q > largest_q) largest_q <= rd_l_q;
            end
            if (k_q == cnt_q) state_q <= S_DONE;
            k_q <= k_q + 1'b1;
          end
        end
        S_DONE: begin
          done_o <= 1'b1;
          status_o <= st_q;
          granted_address_o <= (st_q == ST_OK) ? 32'(grant_q) : '0;
          total_free_o <= total_q[31:0];
          largest_free_o <= largest_q;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
